### rtl/f2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2p_pkg
// Shared types and constants for the float to pcm sample encoder.
// ----------------------------------------------------------------------------
package f2p_pkg;

    typedef enum logic [2:0] {
        FMT_I16LE = 3'd0,
        FMT_I16BE = 3'd1,
        FMT_I24LE = 3'd2,
        FMT_I24BE = 3'd3,
        FMT_I32LE = 3'd4,
        FMT_I32BE = 3'd5,
        FMT_F32LE = 3'd6,
        FMT_F32BE = 3'd7
    } t_fmt;

    localparam logic [30:0] FS16 = 31'h0000_7fff;
    localparam logic [30:0] FS24 = 31'h007f_ffff;
    localparam logic [30:0] FS32 = 31'h7fff_ffff;

    // after the multiply
    typedef struct packed {
        logic        valid;
        logic        last;
        t_fmt        fmt;
        logic [31:0] raw;
        logic        sign;
        logic        sat;
        logic [5:0]  shamt;
        logic [54:0] prod;
    } t_s1;

    // after the double precision rounding
    typedef struct packed {
        logic        valid;
        logic        last;
        t_fmt        fmt;
        logic [31:0] raw;
        logic        sign;
        logic        sat;
        logic [5:0]  shamt;
        logic [55:0] prod;
    } t_s2;

    // after the alignment shift
    typedef struct packed {
        logic        valid;
        logic        last;
        t_fmt        fmt;
        logic [31:0] raw;
        logic        sign;
        logic        sat;
        logic [31:0] quot;
        logic        half;
        logic        sticky;
    } t_s3;

    function automatic logic [30:0] full_scale(input t_fmt fmt);
        logic [30:0] fs;
        unique case (fmt)
            FMT_I16LE, FMT_I16BE: fs = FS16;
            FMT_I24LE, FMT_I24BE: fs = FS24;
            default:              fs = FS32;
        endcase
        return fs;
    endfunction

endpackage

### rtl/f2p_mult.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2p_mult
// Unpacks the sample, classifies it and multiplies the significand by full scale.
// ----------------------------------------------------------------------------
module f2p_mult import f2p_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic        i_last,
    input  t_fmt        i_fmt,
    input  logic [31:0] i_bits,
    output t_s1         o_s1
);

    t_s1         r_s1;
    t_s1         n_s1;
    logic [7:0]  exp_f;
    logic [23:0] mant;
    logic [8:0]  sh;

    always_comb begin
        exp_f       = i_bits[30:23];
        mant        = {1'b1, i_bits[22:0]};
        sh          = 9'd149 - {1'b0, exp_f};
        n_s1.valid  = i_valid;
        n_s1.last   = i_last;
        n_s1.fmt    = i_fmt;
        n_s1.raw    = i_bits;
        n_s1.sign   = i_bits[31];
        n_s1.sat    = 1'b0;
        n_s1.shamt  = (sh > 9'd56) ? 6'd56 : sh[5:0];
        n_s1.prod   = {31'd0, mant} * {24'd0, full_scale(i_fmt)};
        if (exp_f == 8'hff && i_bits[22:0] != 23'd0) begin
            // nan gives zero
            n_s1.prod = '0;
        end else if (exp_f >= 8'd127) begin
            n_s1.sat  = 1'b1;
        end else if (exp_f == 8'd0) begin
            n_s1.prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

### rtl/f2p_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2p_round
// Rounds the product to 53 significant bits, then aligns it to the integer point.
// ----------------------------------------------------------------------------
module f2p_round import f2p_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_s1  i_s1,
    output t_s3  o_s3
);

    t_s2         r_s2;
    t_s2         n_s2;
    t_s3         r_s3;
    t_s3         n_s3;
    logic        inc;
    logic [55:0] aligned;
    logic [55:0] mask;

    always_comb begin
        n_s2.valid = i_s1.valid;
        n_s2.last  = i_s1.last;
        n_s2.fmt   = i_s1.fmt;
        n_s2.raw   = i_s1.raw;
        n_s2.sign  = i_s1.sign;
        n_s2.sat   = i_s1.sat;
        n_s2.shamt = i_s1.shamt;
        inc        = 1'b0;
        priority if (i_s1.prod[54]) begin
            inc       = i_s1.prod[1] & (i_s1.prod[0] | i_s1.prod[2]);
            n_s2.prod = {({1'b0, i_s1.prod[54:2]} + {53'd0, inc}), 2'b00};
        end else if (i_s1.prod[53]) begin
            inc       = i_s1.prod[0] & i_s1.prod[1];
            n_s2.prod = {1'b0, ({1'b0, i_s1.prod[53:1]} + {53'd0, inc}), 1'b0};
        end else begin
            n_s2.prod = {1'b0, i_s1.prod};
        end
    end

    always_comb begin
        aligned     = r_s2.prod >> r_s2.shamt;
        mask        = ~({56{1'b1}} << r_s2.shamt);
        n_s3.valid  = r_s2.valid;
        n_s3.last   = r_s2.last;
        n_s3.fmt    = r_s2.fmt;
        n_s3.raw    = r_s2.raw;
        n_s3.sign   = r_s2.sign;
        n_s3.sat    = r_s2.sat;
        n_s3.quot   = aligned[32:1];
        n_s3.half   = aligned[0];
        n_s3.sticky = |(r_s2.prod & mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (i_en) begin
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

### rtl/f2p_pack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2p_pack
// Final integer rounding, sign and byte layout into the output register.
// ----------------------------------------------------------------------------
module f2p_pack import f2p_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_s3         i_s3,
    output logic        o_valid,
    output logic        o_last,
    output logic [31:0] o_word,
    output logic [2:0]  o_bytes
);

    logic        r_valid;
    logic        r_last;
    logic [31:0] r_word;
    logic [2:0]  r_bytes;
    logic [31:0] n_word;
    logic [2:0]  n_bytes;
    logic [31:0] mag;
    logic [31:0] val;
    logic [31:0] rb;

    always_comb begin
        if (i_s3.sat) begin
            mag = {1'b0, full_scale(i_s3.fmt)};
        end else begin
            mag = i_s3.quot + {31'd0, i_s3.half & (i_s3.sticky | i_s3.quot[0])};
        end
        val     = i_s3.sign ? (32'd0 - mag) : mag;
        rb      = i_s3.raw;
        n_bytes = 3'd4;
        unique case (i_s3.fmt)
            FMT_I16LE: begin
                n_word  = {16'd0, val[15:0]};
                n_bytes = 3'd2;
            end
            FMT_I16BE: begin
                n_word  = {16'd0, val[7:0], val[15:8]};
                n_bytes = 3'd2;
            end
            FMT_I24LE: begin
                n_word  = {8'd0, val[23:0]};
                n_bytes = 3'd3;
            end
            FMT_I24BE: begin
                n_word  = {8'd0, val[7:0], val[15:8], val[23:16]};
                n_bytes = 3'd3;
            end
            FMT_I32LE: n_word = val;
            FMT_I32BE: n_word = {val[7:0], val[15:8], val[23:16], val[31:24]};
            FMT_F32LE: n_word = rb;
            FMT_F32BE: n_word = {rb[7:0], rb[15:8], rb[23:16], rb[31:24]};
            default:   n_word = rb;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_s3.valid;
            r_last  <= i_s3.last;
            r_word  <= n_word;
            r_bytes <= n_bytes;
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_word  = r_word;
    assign o_bytes = r_bytes;

endmodule

### rtl/float_to_pcm_sample_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pipeline: 4 register stages, in this order
// (multiply, double rounding, alignment shift, integer rounding and byte layout)
// throughput: one sample per cycle; every stage stalls while output is held
// reset: synchronous active low, clears the stage valids and out_format to 0
// ----------------------------------------------------------------------------
// float_to_pcm_sample_encoder
// Converts float32 audio samples to 16/24/32-bit pcm or byte-ordered float32.
// ----------------------------------------------------------------------------
module float_to_pcm_sample_encoder import f2p_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // sample_bits
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // out_word, out_bytes, zero pad
    output logic        o_m_axis_tlast
);

    t_fmt        r_fmt;
    logic        en;
    t_s1         s1;
    t_s3         s3;
    logic [31:0] word;
    logic [2:0]  nbytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_I16LE;
        end else if (i_cfg_we) begin
            r_fmt <= t_fmt'(i_cfg_wdata);
        end
    end

    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    f2p_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_s_axis_tvalid),
        .i_last  (i_s_axis_tlast),
        .i_fmt   (r_fmt),
        .i_bits  (i_s_axis_tdata),
        .o_s1    (s1)
    );

    f2p_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_s1    (s1),
        .o_s3    (s3)
    );

    f2p_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_s3    (s3),
        .o_valid (o_m_axis_tvalid),
        .o_last  (o_m_axis_tlast),
        .o_word  (word),
        .o_bytes (nbytes)
    );

    assign o_m_axis_tdata = {5'd0, nbytes, word};

endmodule
